@@ design/tasp_pkg.sv @@
// Package with command codes, direction indexes and port widths for the two-axis stepper positioner.
package tasp_pkg;

	// Command codes carried in the input tuser field.
	localparam logic [1:0] CMD_SET  = 2'd0;
	localparam logic [1:0] CMD_RUN  = 2'd1;
	localparam logic [1:0] CMD_TICK = 2'd2;

	// Direction flag bit positions; the phase counters use the same order.
	localparam logic [1:0] DIR_LEFT  = 2'd0;
	localparam logic [1:0] DIR_RIGHT = 2'd1;
	localparam logic [1:0] DIR_UP    = 2'd2;
	localparam logic [1:0] DIR_DOWN  = 2'd3;

	localparam int POS_W   = 8;
	localparam int NUM_DIR = 4;
	localparam int PHASE_W = 2;

	// Packed stream widths; the tdata widths are rounded up to whole bytes.
	localparam int IN_DATA_W  = 16;
	localparam int IN_USER_W  = 2;
	localparam int OUT_DATA_W = 16;

	// One result item, lowest field last in the declaration.
	typedef struct packed {
		logic [POS_W-1:0]   remaining;
		logic               released;
		logic               moving_v;
		logic               moving_h;
		logic [PHASE_W-1:0] phase;
		logic               step_axis;
		logic               stepped;
	} result_t;

endpackage

@@ design/two_axis_stepper_positioner.sv @@
// Top level of the two-axis stepper positioner: command decode, axis state and result register.

// The block takes one command item per cycle and returns exactly one result item for each,
// shown in the cycle after acceptance. The axis state is updated in the accepting cycle and the result
// waits in an output register; the input side stays ready while that register is empty or
// being taken, so a steady stream runs at one item per clock. A set command (tuser 0) stores
// the target as the axis position at once and loads the step count with the distance, a run
// command (tuser 1) arms motion, and a tick (tuser 2) makes one full step or, when disarmed or
// out of steps, releases the coils and clears both lamps. The phase output is the coil pattern
// index; the coil patterns themselves are left to the driver.
module two_axis_stepper_positioner (
	input  logic                            clk,
	input  logic                            arst_n,
	// Input items.
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// tdata fields from bit 0: axis[0], target[8:1], zero fill.
	input  logic [tasp_pkg::IN_DATA_W-1:0]  s_tdata,
	// tuser fields from bit 0: command[1:0].
	input  logic [tasp_pkg::IN_USER_W-1:0]  s_tuser,
	// Result items.
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// tdata fields from bit 0: stepped[0], step_axis[1], phase[3:2], moving_h[4],
	// moving_v[5], released[6], remaining[14:7], zero fill.
	output logic [tasp_pkg::OUT_DATA_W-1:0] m_tdata
);

	logic [1:0]                  command;
	logic                        axis;
	logic [tasp_pkg::POS_W-1:0]  target;
	logic                        accept;

	logic [tasp_pkg::POS_W-1:0]   pos_h_q, pos_v_q, steps_left_q;
	logic                         armed_q, lamp_h_q, lamp_v_q;
	logic [tasp_pkg::NUM_DIR-1:0] dir_flags_q;
	logic [tasp_pkg::PHASE_W-1:0] phase_cnt_q [tasp_pkg::NUM_DIR];

	logic [tasp_pkg::POS_W-1:0]   pos_h_d, pos_v_d, steps_left_d, cur_pos;
	logic                         armed_d, lamp_h_d, lamp_v_d;
	logic [tasp_pkg::NUM_DIR-1:0] dir_flags_d;
	logic                         dir_found;
	logic [1:0]                   dir_sel;
	logic [tasp_pkg::PHASE_W-1:0] kr;
	logic                         do_step;
	tasp_pkg::result_t            res_d, res_q;

	assign command = s_tuser[1:0];
	assign axis    = s_tdata[0];
	assign target  = s_tdata[8:1];

	// The input side is open while the result register is free or drains this cycle.
	assign s_tready = !m_tvalid || m_tready;
	assign accept   = s_tvalid && s_tready;

	// Pick the active direction in the order left, right, down, up.
	always_comb begin
		dir_found = 1'b1;
		dir_sel   = tasp_pkg::DIR_LEFT;
		if (dir_flags_q[tasp_pkg::DIR_LEFT]) begin
			dir_sel = tasp_pkg::DIR_LEFT;
		end else if (dir_flags_q[tasp_pkg::DIR_RIGHT]) begin
			dir_sel = tasp_pkg::DIR_RIGHT;
		end else if (dir_flags_q[tasp_pkg::DIR_DOWN]) begin
			dir_sel = tasp_pkg::DIR_DOWN;
		end else if (dir_flags_q[tasp_pkg::DIR_UP]) begin
			dir_sel = tasp_pkg::DIR_UP;
		end else begin
			dir_found = 1'b0;
		end
	end

	assign kr      = phase_cnt_q[dir_sel];
	assign cur_pos = axis ? pos_v_q : pos_h_q;

	// Next state and result for the item at the input.
	always_comb begin
		pos_h_d      = pos_h_q;
		pos_v_d      = pos_v_q;
		steps_left_d = steps_left_q;
		armed_d      = armed_q;
		lamp_h_d     = lamp_h_q;
		lamp_v_d     = lamp_v_q;
		dir_flags_d  = dir_flags_q;
		do_step      = 1'b0;
		res_d        = '0;

		case (command)
			tasp_pkg::CMD_SET: begin
				// An equal target leaves everything as it is.
				if (cur_pos > target) begin
					dir_flags_d  = '0;
					dir_flags_d[axis ? tasp_pkg::DIR_DOWN : tasp_pkg::DIR_LEFT] = 1'b1;
					steps_left_d = cur_pos - target;
				end else if (target > cur_pos) begin
					dir_flags_d  = '0;
					dir_flags_d[axis ? tasp_pkg::DIR_UP : tasp_pkg::DIR_RIGHT] = 1'b1;
					steps_left_d = target - cur_pos;
				end
				if (cur_pos != target) begin
					if (axis) begin
						pos_v_d = target;
					end else begin
						pos_h_d = target;
					end
				end
			end
			tasp_pkg::CMD_RUN: begin
				armed_d = 1'b1;
			end
			tasp_pkg::CMD_TICK: begin
				if (armed_q && steps_left_q != '0) begin
					if (dir_found) begin
						do_step         = 1'b1;
						res_d.stepped   = 1'b1;
						res_d.step_axis = (dir_sel == tasp_pkg::DIR_UP) ||
						                  (dir_sel == tasp_pkg::DIR_DOWN);
						// Right and down walk the patterns backward.
						res_d.phase     = ((dir_sel == tasp_pkg::DIR_RIGHT) ||
						                   (dir_sel == tasp_pkg::DIR_DOWN)) ? ~kr : kr;
						if (res_d.step_axis) begin
							lamp_v_d = 1'b1;
						end else begin
							lamp_h_d = 1'b1;
						end
						steps_left_d = steps_left_q - 1'b1;
					end
				end else begin
					// Idle tick: release the coils and disarm.
					steps_left_d   = '0;
					armed_d        = 1'b0;
					lamp_h_d       = 1'b0;
					lamp_v_d       = 1'b0;
					res_d.released = 1'b1;
				end
			end
			default: begin
			end
		endcase

		res_d.moving_h  = lamp_h_d;
		res_d.moving_v  = lamp_v_d;
		res_d.remaining = steps_left_d;
	end

	// Axis state, updated when an item is accepted.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_h_q      <= '0;
			pos_v_q      <= '0;
			steps_left_q <= '0;
			armed_q      <= 1'b0;
			lamp_h_q     <= 1'b0;
			lamp_v_q     <= 1'b0;
			dir_flags_q  <= '0;
			for (int i = 0; i < tasp_pkg::NUM_DIR; i++) begin
				phase_cnt_q[i] <= '0;
			end
		end else if (accept) begin
			pos_h_q      <= pos_h_d;
			pos_v_q      <= pos_v_d;
			steps_left_q <= steps_left_d;
			armed_q      <= armed_d;
			lamp_h_q     <= lamp_h_d;
			lamp_v_q     <= lamp_v_d;
			dir_flags_q  <= dir_flags_d;
			if (do_step) begin
				phase_cnt_q[dir_sel] <= kr + 1'b1;
			end
		end
	end

	// Output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (s_tready) begin
			m_tvalid <= s_tvalid;
		end
	end

	// Result payload register.
	always_ff @(posedge clk) begin
		if (accept) begin
			res_q <= res_d;
		end
	end

	assign m_tdata = {{(tasp_pkg::OUT_DATA_W - $bits(tasp_pkg::result_t)){1'b0}}, res_q};

endmodule

@@ sim/tb_two_axis_stepper_positioner.sv @@
// Self-checking testbench for the two-axis stepper positioner: directed moves, then random moves.
module tb_two_axis_stepper_positioner;
	timeunit 1ns;
	timeprecision 1ps;

	// The fourth command code has no meaning and must leave the state alone.
	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam int RES_W = $bits(tasp_pkg::result_t);
	localparam int CYCLE_LIMIT = 200000;
	localparam int MAX_REPORTS = 10;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [tasp_pkg::IN_DATA_W-1:0] s_tdata = '0;
	logic [tasp_pkg::IN_USER_W-1:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [tasp_pkg::OUT_DATA_W-1:0] m_tdata;

	// Predicted axis state, starting from the reset values.
	logic [tasp_pkg::POS_W-1:0] axis_pos_h = '0;
	logic [tasp_pkg::POS_W-1:0] axis_pos_v = '0;
	logic [tasp_pkg::POS_W-1:0] steps_to_go = '0;
	logic run_armed = 1'b0;
	logic [tasp_pkg::NUM_DIR-1:0] dir_onehot = '0;
	logic [tasp_pkg::PHASE_W-1:0] phase_ctr [tasp_pkg::NUM_DIR] = '{default: '0};
	logic lamp_h = 1'b0;
	logic lamp_v = 1'b0;

	tasp_pkg::result_t pending_status [$];
	int mismatch_count = 0;
	int cycle_count = 0;
	int items_sent = 0;
	int ready_hold = 0;
	bit back_to_back = 1'b0;

	two_axis_stepper_positioner dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	always #1 clk = ~clk;

	// Idle length: mostly none, often short, now and then long.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(4, 20);
	endfunction

	// Applies one command to the predicted state and returns the status the block should report.
	function automatic tasp_pkg::result_t predict_status(input logic [1:0] cmd, input logic ax,
			input logic [tasp_pkg::POS_W-1:0] tgt);
		tasp_pkg::result_t r;
		logic [tasp_pkg::POS_W-1:0] cur;
		logic [1:0] scan [tasp_pkg::NUM_DIR];
		logic [1:0] d;
		logic [tasp_pkg::PHASE_W-1:0] k;
		int i;
		r = '0;
		// Ticks look for the active direction in this priority order.
		scan = '{tasp_pkg::DIR_LEFT, tasp_pkg::DIR_RIGHT, tasp_pkg::DIR_DOWN, tasp_pkg::DIR_UP};
		if (cmd == tasp_pkg::CMD_SET) begin
			cur = ax ? axis_pos_v : axis_pos_h;
			if (cur > tgt) begin
				dir_onehot = 4'b0001 << (ax ? tasp_pkg::DIR_DOWN : tasp_pkg::DIR_LEFT);
				steps_to_go = cur - tgt;
			end else if (tgt > cur) begin
				dir_onehot = 4'b0001 << (ax ? tasp_pkg::DIR_UP : tasp_pkg::DIR_RIGHT);
				steps_to_go = tgt - cur;
			end
			if (ax) axis_pos_v = tgt;
			else axis_pos_h = tgt;
		end else if (cmd == tasp_pkg::CMD_RUN) begin
			run_armed = 1'b1;
		end else if (cmd == tasp_pkg::CMD_TICK) begin
			if (run_armed && steps_to_go != 0) begin
				for (i = 0; i < tasp_pkg::NUM_DIR; i++) begin
					d = scan[i];
					if (dir_onehot[d]) begin
						k = phase_ctr[d];
						// Right and down walk the coil patterns backwards.
						r.phase = (d == tasp_pkg::DIR_RIGHT || d == tasp_pkg::DIR_DOWN) ?
							2'd3 - k : k;
						phase_ctr[d] = k + 2'd1;
						r.step_axis = (d == tasp_pkg::DIR_UP || d == tasp_pkg::DIR_DOWN);
						if (r.step_axis) lamp_v = 1'b1;
						else lamp_h = 1'b1;
						steps_to_go = steps_to_go - 1'b1;
						r.stepped = 1'b1;
						break;
					end
				end
			end else begin
				// Idle tick: release the coils, disarm and clear the lamps.
				steps_to_go = '0;
				run_armed = 1'b0;
				lamp_h = 1'b0;
				lamp_v = 1'b0;
				r.released = 1'b1;
			end
		end
		r.moving_h = lamp_h;
		r.moving_v = lamp_v;
		r.remaining = steps_to_go;
		return r;
	endfunction

	// Sends one command item and records the status it should produce.
	task automatic issue_command(input logic [1:0] cmd, input logic ax,
			input logic [tasp_pkg::POS_W-1:0] tgt);
		int g;
		g = back_to_back ? 0 : pick_gap();
		if (g != 0) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
			repeat (g - 1) @(negedge clk);
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= {{(tasp_pkg::IN_DATA_W - tasp_pkg::POS_W - 1){1'b0}}, tgt, ax};
		do @(posedge clk); while (!s_tready);
		pending_status.push_back(predict_status(cmd, ax, tgt));
		items_sent++;
	endtask

	task automatic note_mismatch(input string field, input int want, input int got);
		mismatch_count++;
		if (mismatch_count <= MAX_REPORTS)
			$display("status mismatch on %s: expected %0d, got %0d", field, want, got);
	endtask

	// Result side stalls at random, except during back-to-back stretches.
	always @(negedge clk) begin
		int g;
		if (back_to_back) begin
			m_tready <= 1'b1;
		end else if (ready_hold != 0) begin
			m_tready <= 1'b0;
			ready_hold <= ready_hold - 1;
		end else begin
			g = pick_gap();
			m_tready <= (g == 0);
			ready_hold <= (g == 0) ? 0 : g - 1;
		end
	end

	// Compare every accepted status item with the oldest prediction; also watch the run time.
	always @(posedge clk) begin
		tasp_pkg::result_t got;
		tasp_pkg::result_t want;
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end else if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata[RES_W-1:0];
			if (m_tdata[tasp_pkg::OUT_DATA_W-1:RES_W] != '0)
				note_mismatch("zero fill", 0, m_tdata[tasp_pkg::OUT_DATA_W-1:RES_W]);
			if (pending_status.size() == 0) begin
				note_mismatch("unexpected item", 0, m_tdata);
			end else begin
				want = pending_status.pop_front();
				if (got.stepped != want.stepped)
					note_mismatch("stepped", want.stepped, got.stepped);
				if (got.step_axis != want.step_axis)
					note_mismatch("step_axis", want.step_axis, got.step_axis);
				if (got.phase != want.phase)
					note_mismatch("phase", want.phase, got.phase);
				if (got.moving_h != want.moving_h)
					note_mismatch("moving_h", want.moving_h, got.moving_h);
				if (got.moving_v != want.moving_v)
					note_mismatch("moving_v", want.moving_v, got.moving_v);
				if (got.released != want.released)
					note_mismatch("released", want.released, got.released);
				if (got.remaining != want.remaining)
					note_mismatch("remaining", want.remaining, got.remaining);
			end
		end
	end

	// Ticks with nothing armed, and armed with no steps, both release the coils.
	task automatic test_idle_release();
		issue_command(tasp_pkg::CMD_TICK, 1'b1, 8'hFF);
		issue_command(tasp_pkg::CMD_RUN, 1'b0, 8'h00);
		issue_command(tasp_pkg::CMD_TICK, 1'b0, 8'h00);
	endtask

	// Full-range horizontal moves, one-step vertical moves, a set to the current position and a set while armed.
	task automatic test_set_and_step();
		issue_command(tasp_pkg::CMD_SET, 1'b0, 8'hFF);
		issue_command(tasp_pkg::CMD_SET, 1'b0, 8'hFF);
		issue_command(tasp_pkg::CMD_RUN, 1'b1, 8'h55);
		repeat (4) issue_command(tasp_pkg::CMD_TICK, 1'b0, 8'hAA);
		issue_command(tasp_pkg::CMD_SET, 1'b1, 8'h01);
		issue_command(tasp_pkg::CMD_TICK, 1'b1, 8'h00);
		issue_command(tasp_pkg::CMD_TICK, 1'b1, 8'h00);
		issue_command(tasp_pkg::CMD_SET, 1'b0, 8'h00);
		issue_command(tasp_pkg::CMD_RUN, 1'b0, 8'h00);
		repeat (2) issue_command(tasp_pkg::CMD_TICK, 1'b0, 8'h00);
		issue_command(tasp_pkg::CMD_SET, 1'b1, 8'h00);
		repeat (2) issue_command(tasp_pkg::CMD_TICK, 1'b1, 8'hFF);
	endtask

	// The unused command code must only report the current lamps and count.
	task automatic test_unused_command();
		issue_command(CMD_UNUSED, 1'b1, 8'hAA);
		issue_command(CMD_UNUSED, 1'b0, 8'h55);
	endtask

	// Mostly set, run and tick sequences with random targets, plus some random noise items.
	task automatic test_random_moves(input int n_items);
		int stop_at;
		int ticks;
		int t;
		logic ax;
		logic [tasp_pkg::POS_W-1:0] cur;
		stop_at = items_sent + n_items;
		while (items_sent < stop_at) begin
			back_to_back = ($urandom_range(0, 4) == 0);
			if ($urandom_range(0, 9) == 0) begin
				repeat ($urandom_range(1, 6))
					issue_command(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
						8'($urandom_range(0, 255)));
			end else begin
				ax = 1'($urandom_range(0, 1));
				cur = ax ? axis_pos_v : axis_pos_h;
				// Short moves dominate so that most sequences run to the release.
				if ($urandom_range(0, 7) == 0) begin
					t = $urandom_range(0, 255);
				end else begin
					t = $urandom_range(0, 1) ? cur + $urandom_range(0, 7) : cur - $urandom_range(0, 7);
					if (t < 0) t = 0;
					if (t > 255) t = 255;
				end
				issue_command(tasp_pkg::CMD_SET, ax, 8'(t));
				issue_command(tasp_pkg::CMD_RUN, 1'($urandom_range(0, 1)),
					8'($urandom_range(0, 255)));
				if ($urandom_range(0, 4) == 0) begin
					// Retarget in the middle of a move.
					repeat ($urandom_range(1, 3))
						issue_command(tasp_pkg::CMD_TICK, 1'($urandom_range(0, 1)),
							8'($urandom_range(0, 255)));
					issue_command(tasp_pkg::CMD_SET, 1'($urandom_range(0, 1)),
						8'($urandom_range(0, 255)));
				end
				ticks = steps_to_go + $urandom_range(0, 2);
				if (ticks > 12) ticks = $urandom_range(2, 12);
				repeat (ticks)
					issue_command(tasp_pkg::CMD_TICK, 1'($urandom_range(0, 1)),
						8'($urandom_range(0, 255)));
			end
		end
		back_to_back = 1'b0;
	endtask

	initial begin
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_idle_release();
		test_set_and_step();
		test_unused_command();
		test_random_moves(450);
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending_status.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		if (mismatch_count == 0 && pending_status.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
